### hw/rtl/lsp_pkg.sv
// Shared types and constants for the LSB steganography payload extractor.
// No dependencies; used by every module of the block.
package lsp_pkg;

  // Queue depth between the pixel front end and the decoder back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Width of a name or payload unit and of the size word, in bits.
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned SIZE_BITS = 32;

  // Channel select codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TERM = 2'd1,
    KIND_SIZE = 2'd2,
    KIND_DATA = 2'd3
  } kind_e;

  // One classified pixel: start flag plus the LSB of each color channel.
  typedef struct packed {
    logic       start;
    logic [2:0] lsbs;   // [2] red, [1] green, [0] blue
  } token_t;

endpackage

### hw/rtl/lsp_front.sv
// Pixel front end: registers an accepted pixel, keeps only its channel LSBs
// and the start flag, and pushes the token into the queue. Uses lsp_pkg.
module lsp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [23:0]     pixel_rgb_i,
  input  logic            start_req_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output lsp_pkg::token_t q_token_o
);

  logic            stage_valid_q, stage_valid_d;
  lsp_pkg::token_t stage_q;
  logic            accept;

  assign in_stall_o = stage_valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = stage_valid_q & ~q_full_i;
  assign q_token_o  = stage_q;

  // Hold the stage while the queue is full, refill it when it drains.
  always_comb begin
    stage_valid_d = stage_valid_q;
    if (q_push_o || !stage_valid_q) begin
      stage_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.start <= start_req_i;
      stage_q.lsbs  <= {pixel_rgb_i[16], pixel_rgb_i[8], pixel_rgb_i[0]};
    end
  end

endmodule

### hw/rtl/lsp_fifo.sv
// Short token queue between front end and decoder back end.
// Uses lsp_pkg for the token type.
module lsp_fifo #(
  parameter int unsigned Depth = lsp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lsp_pkg::token_t token_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lsp_pkg::token_t token_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lsp_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

### hw/rtl/lsp_back.sv
// Decoder back end: channel rotation, bit gathering, phase sequencing and
// the registered result beat. Uses lsp_pkg types and constants.
module lsp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  lsp_pkg::token_t q_token_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [31:0]     value_o,
  output logic            last_o
);

  lsp_pkg::phase_e phase_q, phase_d;
  logic [1:0]      chan_q, chan_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [31:0]     shift_q, shift_d;
  logic [30:0]     left_q, left_d;

  logic            out_valid_q, out_valid_d;
  lsp_pkg::kind_e  kind_q, kind_d;
  logic [31:0]     value_q, value_d;
  logic            last_q, last_d;
  logic            produce;

  always_comb begin
    lsp_pkg::phase_e ph;
    logic [1:0]      ch;
    logic [4:0]      cnt;
    logic [31:0]     sw;
    logic [30:0]     left;
    logic [30:0]     left_dec;
    logic            bit_in;
    logic            unit_done;

    ph   = phase_q;
    ch   = chan_q;
    cnt  = cnt_q;
    left = left_q;
    sw   = shift_q;
    if (q_token_i.start) begin
      ph   = lsp_pkg::PH_NAME;
      ch   = lsp_pkg::CH_RED;
      cnt  = '0;
      left = '0;
      sw   = '0;
    end

    phase_d = ph;
    chan_d  = ch;
    cnt_d   = cnt;
    left_d  = left;
    shift_d = sw;
    produce = 1'b0;
    kind_d  = lsp_pkg::KIND_CHAR;
    value_d = '0;
    last_d  = 1'b0;

    unique case (ch)
      lsp_pkg::CH_RED:   bit_in = q_token_i.lsbs[2];
      lsp_pkg::CH_GREEN: bit_in = q_token_i.lsbs[1];
      lsp_pkg::CH_BLUE:  bit_in = q_token_i.lsbs[0];
      default:           bit_in = 1'b0;
    endcase

    if (ph == lsp_pkg::PH_SIZE) begin
      unit_done = ({1'b0, cnt} + 6'd1) >= 6'(lsp_pkg::SIZE_BITS);
    end else begin
      unit_done = ({1'b0, cnt} + 6'd1) >= 6'(lsp_pkg::BYTE_BITS);
    end
    left_dec = (left != '0) ? left - 31'd1 : '0;

    if (ph != lsp_pkg::PH_DONE) begin
      chan_d = (ch >= lsp_pkg::CH_BLUE) ? lsp_pkg::CH_RED : ch + 2'd1;
      sw     = {sw[30:0], bit_in};
      if (!unit_done) begin
        cnt_d   = cnt + 5'd1;
        shift_d = sw;
      end else begin
        cnt_d   = '0;
        shift_d = '0;
        produce = 1'b1;
        unique case (ph)
          lsp_pkg::PH_NAME: begin
            if (sw[7:0] == 8'h00) begin
              phase_d = lsp_pkg::PH_SIZE;
              kind_d  = lsp_pkg::KIND_TERM;
            end else begin
              kind_d  = lsp_pkg::KIND_CHAR;
              value_d = {24'd0, sw[7:0]};
            end
          end
          lsp_pkg::PH_SIZE: begin
            // A size with its top bit set counts as an empty payload.
            left_d  = sw[31] ? '0 : sw[30:0];
            kind_d  = lsp_pkg::KIND_SIZE;
            value_d = sw;
            last_d  = sw[31] || (sw[30:0] == '0);
            phase_d = last_d ? lsp_pkg::PH_DONE : lsp_pkg::PH_DATA;
          end
          default: begin
            left_d  = left_dec;
            kind_d  = lsp_pkg::KIND_DATA;
            value_d = {24'd0, sw[7:0]};
            last_d  = (left_dec == '0);
            phase_d = last_d ? lsp_pkg::PH_DONE : lsp_pkg::PH_DATA;
          end
        endcase
      end
    end
  end

  // Take a token unless it yields a result and the output beat is stuck.
  assign q_pop_o = q_valid_i & (~produce | ~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (q_pop_o && produce) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lsp_pkg::PH_NAME;
      chan_q      <= lsp_pkg::CH_RED;
      cnt_q       <= '0;
      shift_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        phase_q <= phase_d;
        chan_q  <= chan_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        left_q  <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && produce) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/lsb_stego_payload_extractor_top.sv
// Each accepted pixel is staged, queued, then decoded into a registered beat.
// Throughput: one pixel per cycle unless stalled; back end retires one token a
// cycle and waits only when a result beat is due and the output is stalled.
// Reset (rst_ni low, asynchronous) empties the stage and queue, drops any
// pending beat and puts the decoder in the name phase on the red channel.
// Top level of the LSB steganography payload extractor; uses lsp_pkg.
module lsb_stego_payload_extractor_top #(
  parameter int unsigned QueueDepth = lsp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] pixel_rgb_i,
  input  logic        start_req_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] value_o,
  output logic        last_o
);

  // Front end to queue.
  logic            push;
  logic            full;
  lsp_pkg::token_t push_token;

  // Queue to back end.
  logic            pop;
  logic            tok_valid;
  lsp_pkg::token_t tok;

  // Register each pixel beat, keep just the three channel LSBs and the
  // start flag; stall only when the stage is held and the queue is full.
  lsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_rgb_i (pixel_rgb_i),
    .start_req_i (start_req_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_token_o   (push_token)
  );

  // Decouple the two sides so the front keeps taking pixels while a
  // result beat waits downstream.
  lsp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_token),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (tok_valid),
    .token_o (tok)
  );

  // Advance the decoder: name bytes, terminator, size word, payload bytes,
  // then idle until a start flag.
  lsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (tok_valid),
    .q_token_i   (tok),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule

### hw/rtl/lsp_checker.sv
// Port-level checks for the LSB steganography payload extractor, bound to
// the top level. Uses lsp_pkg for the result kind codes.
module lsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [31:0] value_o,
  input logic        last_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(kind_o) && $stable(value_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // A name terminator carries zero and never ends the stream.
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lsp_pkg::KIND_TERM) |-> (value_o == '0) && !last_o)
    else $error("bad name terminator beat");

  // Name characters are nonzero bytes and never end the stream.
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lsp_pkg::KIND_CHAR) |->
      (value_o[31:8] == '0) && (value_o[7:0] != 8'h00) && !last_o)
    else $error("bad name character beat");

  // Payload beats carry a byte only.
  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lsp_pkg::KIND_DATA) |-> (value_o[31:8] == '0))
    else $error("payload beat wider than a byte");

  // An empty or negative size ends the stream on the size beat.
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == lsp_pkg::KIND_SIZE) |->
      (last_o == (value_o[31] || (value_o == '0))))
    else $error("size beat last flag wrong");

endmodule

bind lsb_stego_payload_extractor_top lsp_checker u_lsp_checker (.*);

### sim/lsb_stego_payload_extractor_top_test.sv
// Self-checking testbench for lsb_stego_payload_extractor_top: drives pixel beats,
// predicts name, size and payload result beats, and compares them in order.
// Depends on lsp_pkg and the top-level RTL only.
module lsb_stego_payload_extractor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TotalPixels = 1650;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;

  // One expected result beat, at the widths of the result channel.
  typedef struct packed {
    lsp_pkg::kind_e kind;
    logic [31:0]    value;
    logic           last;
  } result_beat_t;

  // Tracks decoder state, predicts result beats and checks them in order.
  class stego_decode_check;
    lsp_pkg::phase_e dec_phase;
    logic [1:0]      chan;
    logic [4:0]      nbits;
    logic [31:0]     shreg;
    logic [30:0]     bytes_left;
    result_beat_t    pending_beats[$];
    int              n_used;
    int              n_beats;
    int              n_err;
    int              by_kind[4];

    function new();
      clear_decoder();
      n_used  = 0;
      n_beats = 0;
      n_err   = 0;
      foreach (by_kind[i]) by_kind[i] = 0;
    endfunction

    function void clear_decoder();
      dec_phase  = lsp_pkg::PH_NAME;
      chan       = lsp_pkg::CH_RED;
      nbits      = '0;
      shreg      = '0;
      bytes_left = '0;
    endfunction

    function void push_beat(lsp_pkg::kind_e k, logic [31:0] v, logic l);
      result_beat_t b;
      b.kind  = k;
      b.value = v;
      b.last  = l;
      pending_beats.push_back(b);
    endfunction

    // Note an accepted pixel beat: advance the decoder and queue any result.
    function void decode_pixel(logic [23:0] px, logic st);
      logic        lsb;
      logic [31:0] word;
      logic [31:0] count;
      int          width_needed;
      if (st) clear_decoder();
      if (dec_phase == lsp_pkg::PH_DONE) return;
      n_used++;
      case (chan)
        lsp_pkg::CH_RED:   lsb = px[16];
        lsp_pkg::CH_GREEN: lsb = px[8];
        lsp_pkg::CH_BLUE:  lsb = px[0];
        default:           lsb = 1'b0;
      endcase
      chan  = (chan >= lsp_pkg::CH_BLUE) ? lsp_pkg::CH_RED : chan + 2'd1;
      shreg = {shreg[30:0], lsb};
      width_needed = (dec_phase == lsp_pkg::PH_SIZE) ? lsp_pkg::SIZE_BITS
                                                     : lsp_pkg::BYTE_BITS;
      if (int'(nbits) + 1 < width_needed) begin
        nbits = nbits + 5'd1;
        return;
      end
      word  = shreg;
      nbits = '0;
      shreg = '0;
      case (dec_phase)
        lsp_pkg::PH_NAME: begin
          if (word[7:0] == 8'h00) begin
            dec_phase = lsp_pkg::PH_SIZE;
            push_beat(lsp_pkg::KIND_TERM, '0, 1'b0);
          end else begin
            push_beat(lsp_pkg::KIND_CHAR, {24'h0, word[7:0]}, 1'b0);
          end
        end
        lsp_pkg::PH_SIZE: begin
          // A size with its top bit set means an empty payload.
          count      = word[31] ? 32'h0 : word;
          bytes_left = count[30:0];
          dec_phase  = (count == 0) ? lsp_pkg::PH_DONE : lsp_pkg::PH_DATA;
          push_beat(lsp_pkg::KIND_SIZE, word, count == 0);
        end
        default: begin
          if (bytes_left != 0) bytes_left = bytes_left - 31'd1;
          if (bytes_left == 0) begin
            dec_phase = lsp_pkg::PH_DONE;
            push_beat(lsp_pkg::KIND_DATA, {24'h0, word[7:0]}, 1'b1);
          end else begin
            push_beat(lsp_pkg::KIND_DATA, {24'h0, word[7:0]}, 1'b0);
          end
        end
      endcase
    endfunction

    function void check_beat(logic [1:0] k, logic [31:0] v, logic l);
      result_beat_t e;
      n_beats++;
      if (pending_beats.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("[%0t] unexpected result beat: kind %0d value %h last %b", $time, k, v, l);
        return;
      end
      e = pending_beats.pop_front();
      by_kind[e.kind]++;
      if (k !== e.kind || v !== e.value || l !== e.last) begin
        n_err++;
        if (n_err <= 10)
          $display("[%0t] mismatch: kind %0d/%0d value %h/%h last %b/%b (expected/actual)",
                   $time, e.kind, k, e.value, v, e.last, l);
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] pixel = '0;
  logic        start_req = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  res_kind;
  logic [31:0] res_value;
  logic        res_last;

  stego_decode_check sb = new();

  bit img_bits[$];        // bit stream of the image being built, MSB-first per unit
  int burst_left = 0;
  int hold_cnt = 0;       // bumped by the stimulus to request one long output hold-off
  int n_images = 0;
  int n_sent = 0;
  int cycles = 0;

  lsb_stego_payload_extractor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_rgb_i (pixel),
    .start_req_i (start_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (res_kind),
    .value_o     (res_value),
    .last_o      (res_last)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, sb.pending());
      $display("lsb_stego_payload_extractor_top test failed");
      $finish;
    end
  end

  // Receiver: switch between stall patterns every so often; on request, hold
  // off for a long stretch so the internal queue fills and the input stalls.
  int holds_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_cnt != holds_seen) begin
      holds_seen = hold_cnt;
      hold_left  = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 120);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= $urandom_range(0, 1);
        default: out_stall <= (cycles % 5 < 2);
      endcase
    end
  end

  // Monitor: check every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_beat(res_kind, res_value, res_last);
  end

  // Offer one pixel beat, with a random gap at the start of each burst, and
  // hold it until accepted.
  task automatic send_pixel(input logic [23:0] px, input logic st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    pixel     <= px;
    start_req <= st;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.decode_pixel(px, st);
    n_sent++;
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic put_bits(input logic [31:0] v, input int width);
    for (int k = width - 1; k >= 0; k--) img_bits.push_back(v[k]);
  endtask

  // Send the built bit stream as pixels: start flag on the first one, each bit
  // in the LSB of the rotating channel, the other bits set by fill_mode
  // (0 random, 1 zeros, 2 ones). Stop after cut bits when cut >= 0, then send
  // tail pixels without a start flag.
  task automatic send_image(input int cut, input int tail, input int fill_mode);
    logic [23:0] px;
    int          n;
    int          pos;
    n = (cut >= 0 && cut < img_bits.size()) ? cut : img_bits.size();
    for (int i = 0; i < n; i++) begin
      case (fill_mode)
        0:       px = 24'($urandom());
        1:       px = '0;
        default: px = '1;
      endcase
      pos = (i % 3 == 0) ? 16 : (i % 3 == 1) ? 8 : 0;
      px[pos] = img_bits[i];
      send_pixel(px, i == 0);
    end
    repeat (tail) send_pixel((fill_mode == 2) ? 24'hFFFFFF : 24'($urandom()), 1'b0);
    img_bits.delete();
    n_images++;
  endtask

  // Well-formed image with random content; sometimes cut short, sometimes with
  // a size far larger than the payload that follows.
  task automatic random_image();
    int          nlen;
    int          nbytes;
    int          sel;
    int          cut;
    logic [31:0] size_w;
    nlen = $urandom_range(0, 4);
    repeat (nlen) put_bits($urandom_range(1, 255), 8);
    put_bits(32'h0, 8);
    sel = $urandom_range(0, 99);
    if (sel < 8)       size_w = 32'h0;
    else if (sel < 16) size_w = {1'b1, 31'($urandom())};
    else if (sel < 22) size_w = {1'b0, 31'($urandom())};
    else               size_w = $urandom_range(1, 6);
    put_bits(size_w, 32);
    nbytes = (size_w[31] || size_w > 6) ? $urandom_range(0, 3) : int'(size_w);
    repeat (nbytes) put_bits($urandom_range(0, 255), 8);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, img_bits.size()) : -1;
    send_image(cut, (cut < 0) ? $urandom_range(0, 3) : 0, 0);
  endtask

  initial begin
    int  n_directed;
    int  sel;
    bit  held;
    bit  paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme name bytes, zero size, ignored pixels with all bits high.
    put_bits(32'hFF, 8); put_bits(32'h01, 8); put_bits(32'h41, 8); put_bits(32'h0, 8);
    put_bits(32'h0, 32);
    send_image(-1, 3, 2);
    // Empty name, size with top bit set; the start lands in the done phase.
    put_bits(32'h0, 8); put_bits(32'h80000005, 32);
    send_image(-1, 2, 1);
    // Short payload with extreme bytes.
    put_bits(32'h7F, 8); put_bits(32'h0, 8); put_bits(32'd3, 32);
    put_bits(32'h00, 8); put_bits(32'hFF, 8); put_bits(32'h80, 8);
    send_image(-1, 2, 0);
    // All-ones size word.
    put_bits(32'h55, 8); put_bits(32'h0, 8); put_bits(32'hFFFFFFFF, 32);
    send_image(-1, 1, 2);
    // Largest positive size, abandoned after two bytes.
    put_bits(32'h0, 8); put_bits(32'h7FFFFFFF, 32); put_bits(32'hA5, 8); put_bits(32'h5A, 8);
    send_image(-1, 0, 1);
    // Restart in the middle of a name byte.
    put_bits(32'h80, 8); put_bits(32'h3C, 8); put_bits(32'h0, 8);
    send_image(11, 0, 0);
    // Single-byte payload.
    put_bits(32'h0, 8); put_bits(32'd1, 32); put_bits(32'hC3, 8);
    send_image(-1, 2, 0);
    wait_drain();
    n_directed = sb.n_used;

    // Random part: mostly well-formed images, some noise with stray starts.
    while (n_sent < TotalPixels) begin
      if (!held && sb.n_used > n_directed + 400) begin
        hold_cnt <= hold_cnt + 1;
        held = 1'b1;
      end
      if (!paused && sb.n_used > n_directed + 900) begin
        wait_drain();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) repeat ($urandom_range(1, 12))
        send_pixel(24'($urandom()), $urandom_range(0, 7) == 0);
      else random_image();
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("sent %0d pixels, decoded %0d over %0d images; %0d result beats checked",
             n_sent, sb.n_used, n_images, sb.n_beats);
    $display("name chars %0d, terminators %0d, sizes %0d, payload bytes %0d, mismatches %0d",
             sb.by_kind[lsp_pkg::KIND_CHAR], sb.by_kind[lsp_pkg::KIND_TERM],
             sb.by_kind[lsp_pkg::KIND_SIZE], sb.by_kind[lsp_pkg::KIND_DATA], sb.n_err);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("lsb_stego_payload_extractor_top test passed");
    end else begin
      $display("lsb_stego_payload_extractor_top test failed");
    end
    $finish;
  end

endmodule
